// File: rtl/cnaf_pkg.sv
// Shared constants, types and divider step functions for the cell area fraction pipeline.
`timescale 1ns / 1ps
`default_nettype none
package cnaf_pkg;

  localparam int CORNER_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int CFG_W      = 16;
  localparam int THETA_FB   = 28;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STG    = THETA_FB / DIV_BITS;
  localparam int MAG_W      = CORNER_W + 1;
  localparam int REM_W      = MAG_W + 1;
  localparam int THETA_W    = THETA_FB + 1;
  localparam int OPW        = 32;
  localparam int PRODW      = 2 * OPW;
  localparam int SUMW       = PRODW + 2;
  localparam int A2_W       = SUMW + 2;
  localparam int AREA_FB    = 61;
  localparam int AREA_SHIFT = AREA_FB - FRAC_W;
  localparam int NPAIR      = 6;
  localparam int NPROD      = 4;

  localparam logic [CFG_W-1:0] CFG_HEIGHT_RST = CFG_W'(256);

  // Corner sign patterns (bit 0 lower left, 1 lower right, 2 upper left, 3 upper right)
  localparam logic [3:0] PAT_NONE      = 4'd0;
  localparam logic [3:0] PAT_LL        = 4'd1;
  localparam logic [3:0] PAT_LR        = 4'd2;
  localparam logic [3:0] PAT_BOTTOM    = 4'd3;
  localparam logic [3:0] PAT_UL        = 4'd4;
  localparam logic [3:0] PAT_LEFT      = 4'd5;
  localparam logic [3:0] PAT_DIAG_ANTI = 4'd6;
  localparam logic [3:0] PAT_NOT_UR    = 4'd7;
  localparam logic [3:0] PAT_UR        = 4'd8;
  localparam logic [3:0] PAT_DIAG_MAIN = 4'd9;
  localparam logic [3:0] PAT_RIGHT     = 4'd10;
  localparam logic [3:0] PAT_NOT_UL    = 4'd11;
  localparam logic [3:0] PAT_NOT_LR    = 4'd13;
  localparam logic [3:0] PAT_NOT_LL    = 4'd14;
  localparam logic [3:0] PAT_ALL       = 4'd15;

  // One divider lane: |a| * 2^28 / (|a| + |b|), restoring, one quotient bit per iteration, DIV_BITS per div_step
  typedef struct packed {
    logic [REM_W-1:0]    rem;
    logic [MAG_W-1:0]    den;
    logic [THETA_FB-1:0] quo;
    logic                zero;
    logic                full;
  } div_t;

  function automatic logic [MAG_W-1:0] mag(input logic signed [CORNER_W-1:0] v);
    logic signed [MAG_W-1:0] ext;
    ext = MAG_W'(v);
    return v[CORNER_W-1] ? MAG_W'(-ext) : MAG_W'(ext);
  endfunction

  function automatic div_t div_init(input logic signed [CORNER_W-1:0] a,
                                    input logic signed [CORNER_W-1:0] b);
    div_t d;
    logic [MAG_W-1:0] na;
    logic [MAG_W-1:0] nb;
    na     = mag(a);
    nb     = mag(b);
    d.den  = na + nb;
    d.rem  = REM_W'(na);
    d.quo  = '0;
    d.zero = (na == '0) && (nb == '0);
    d.full = (nb == '0) && (na != '0);
    return d;
  endfunction

  function automatic div_t div_step(input div_t din);
    div_t d;
    logic [REM_W-1:0] r2;
    d = din;
    for (int i = 0; i < DIV_BITS; i++) begin
      r2 = {d.rem[REM_W-2:0], 1'b0};
      if (r2 >= REM_W'(d.den)) begin
        d.rem = r2 - REM_W'(d.den);
        d.quo = {d.quo[THETA_FB-2:0], 1'b1};
      end else begin
        d.rem = r2;
        d.quo = {d.quo[THETA_FB-2:0], 1'b0};
      end
    end
    return d;
  endfunction

  // Finished crossing fraction with THETA_FB fraction bits
  function automatic logic [THETA_W-1:0] div_theta(input div_t d);
    logic [THETA_W-1:0] t;
    if (d.zero) t = '0;
    else if (d.full) t = THETA_W'(1) << THETA_FB;
    else t = THETA_W'(d.quo);
    return t;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cell_negative_area_fraction.sv
// Top level: negative area fraction of one level-set cell, fully pipelined.
// Throughput: one cell per cycle unless the output stalls; the depth comes from the
// six crossing dividers, 28 quotient bits at 4 bits per stage, then operand select,
// multiply, sum, round.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, rst_n low) empties the pipeline and sets cell height to 256.
`timescale 1ns / 1ps
`default_nettype none
module cell_negative_area_fraction (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [cnaf_pkg::CORNER_W-1:0]   in_corner_lower_left,
  input  logic signed [cnaf_pkg::CORNER_W-1:0]   in_corner_lower_right,
  input  logic signed [cnaf_pkg::CORNER_W-1:0]   in_corner_upper_left,
  input  logic signed [cnaf_pkg::CORNER_W-1:0]   in_corner_upper_right,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic        [cnaf_pkg::FRAC_W:0]       out_negative_fraction,
  input  logic                                   cfg_wr_en,
  input  logic        [cnaf_pkg::CFG_W-1:0]      cfg_wr_data
);
  import cnaf_pkg::*;

  localparam int NSTG = DIV_STG + 5;
  localparam logic [OPW-1:0] C_ONE  = OPW'(64'h4000_0000);
  localparam logic [OPW-1:0] C_TWO  = OPW'(64'h8000_0000);
  localparam logic [OPW-1:0] C_QTR  = OPW'(64'h1000_0000);
  localparam logic [OPW-1:0] C_HALF = OPW'(64'h2000_0000);
  localparam logic signed [A2_W-1:0] TWICE_ONE = A2_W'(1) <<< AREA_FB;
  localparam logic [AREA_FB:0] RND_HALF = (AREA_FB+1)'(1) << (AREA_SHIFT - 1);

  logic                adv;
  logic [NSTG-1:0]     vld_r;
  logic [CFG_W-1:0]    cfg_height_r;

  div_t                div_r [0:DIV_STG][0:NPAIR-1];
  logic [3:0]          pat_r [0:DIV_STG];

  logic [OPW-1:0]      op_a_nxt [0:NPROD-1];
  logic [OPW-1:0]      op_b_nxt [0:NPROD-1];
  logic                sub_nxt;
  logic                base_nxt;
  logic [OPW-1:0]      op_a_r [0:NPROD-1];
  logic [OPW-1:0]      op_b_r [0:NPROD-1];
  logic                op_sub_r;
  logic                op_base_r;

  logic [PRODW-1:0]    prod_r [0:NPROD-1];
  logic                mul_sub_r;
  logic                mul_base_r;

  logic [SUMW-1:0]     psum;
  logic signed [A2_W-1:0] a2_nxt;
  logic signed [A2_W-1:0] a2_r;

  logic [AREA_FB:0]    a2_clamp;
  logic [AREA_FB:0]    a2_rnd;
  logic [FRAC_W:0]     frac_nxt;
  logic [FRAC_W:0]     frac_r;

  logic [THETA_W-1:0]  th [0:NPAIR-1];
  logic [OPW-1:0]      xb, xt, yl, yr, cx, cy, mx, my;
  logic [3:0]          pat_in;

  // Whole pipeline advances unless a finished beat is held at the output
  assign adv       = !(vld_r[NSTG-1] && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld_r[NSTG-1];
  assign out_negative_fraction = frac_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid};
    end
  end

  // Hold the height register; the exact fraction does not depend on it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_height_r <= CFG_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      cfg_height_r <= cfg_wr_data;
    end
  end

  assign pat_in = {in_corner_upper_right <= 0, in_corner_upper_left <= 0,
                   in_corner_lower_right <= 0, in_corner_lower_left <= 0};

  // Divider lanes: load, then 4 quotient bits per stage
  always_ff @(posedge clk) begin
    if (adv) begin
      div_r[0][0] <= div_init(in_corner_lower_left,  in_corner_lower_right);
      div_r[0][1] <= div_init(in_corner_upper_left,  in_corner_upper_right);
      div_r[0][2] <= div_init(in_corner_lower_left,  in_corner_upper_left);
      div_r[0][3] <= div_init(in_corner_lower_right, in_corner_upper_right);
      div_r[0][4] <= div_init(in_corner_lower_left,  in_corner_upper_right);
      div_r[0][5] <= div_init(in_corner_upper_left,  in_corner_lower_right);
      pat_r[0]    <= pat_in;
      for (int k = 0; k < DIV_STG; k++) begin
        for (int i = 0; i < NPAIR; i++) begin
          div_r[k+1][i] <= div_step(div_r[k][i]);
        end
        pat_r[k+1] <= pat_r[k];
      end
    end
  end

  // Crossing points in coordinates with 30 fraction bits
  always_comb begin
    for (int i = 0; i < NPAIR; i++) begin
      th[i] = div_theta(div_r[DIV_STG][i]);
    end
    xb = OPW'({th[0], 2'b00});
    xt = OPW'({th[1], 2'b00});
    yl = OPW'({th[2], 2'b00});
    yr = OPW'({th[3], 2'b00});
    cx = OPW'(th[0]) + OPW'(th[1]) + C_QTR;
    cy = OPW'(th[2]) + OPW'(th[3]) + C_QTR;
    mx = OPW'({th[4], 1'b0}) + OPW'({th[5], 1'b0});
    my = OPW'({th[4], 1'b0}) + C_HALF - OPW'({th[5], 1'b0});
  end

  // Select the shoelace products for the sign pattern
  always_comb begin
    for (int i = 0; i < NPROD; i++) begin
      op_a_nxt[i] = '0;
      op_b_nxt[i] = '0;
    end
    sub_nxt  = 1'b0;
    base_nxt = 1'b0;
    case (pat_r[DIV_STG])
      PAT_NONE: begin
        base_nxt = 1'b0;
      end
      PAT_ALL: begin
        base_nxt = 1'b1;
      end
      PAT_LL, PAT_NOT_LL: begin
        op_a_nxt[0] = OPW'(th[4]) << 2;
        op_b_nxt[0] = xb + yl;
        sub_nxt  = (pat_r[DIV_STG] == PAT_NOT_LL);
        base_nxt = sub_nxt;
      end
      PAT_LR, PAT_NOT_LR: begin
        op_a_nxt[0] = C_ONE - (OPW'(th[5]) << 2);
        op_b_nxt[0] = yr + C_ONE - xb;
        sub_nxt  = (pat_r[DIV_STG] == PAT_NOT_LR);
        base_nxt = sub_nxt;
      end
      PAT_UL, PAT_NOT_UL: begin
        op_a_nxt[0] = OPW'(th[5]) << 2;
        op_b_nxt[0] = C_ONE - yl + xt;
        sub_nxt  = (pat_r[DIV_STG] == PAT_NOT_UL);
        base_nxt = sub_nxt;
      end
      PAT_UR, PAT_NOT_UR: begin
        op_a_nxt[0] = C_ONE - (OPW'(th[4]) << 2);
        op_b_nxt[0] = C_TWO - xt - yr;
        sub_nxt  = (pat_r[DIV_STG] == PAT_NOT_UR);
        base_nxt = sub_nxt;
      end
      PAT_DIAG_MAIN: begin
        op_a_nxt[0] = xb;          op_b_nxt[0] = cy;
        op_a_nxt[1] = yl;          op_b_nxt[1] = cx;
        op_a_nxt[2] = C_ONE - xt;  op_b_nxt[2] = C_ONE - cy;
        op_a_nxt[3] = C_ONE - yr;  op_b_nxt[3] = C_ONE - cx;
      end
      PAT_DIAG_ANTI: begin
        op_a_nxt[0] = yr;          op_b_nxt[0] = C_ONE - cx;
        op_a_nxt[1] = cy;          op_b_nxt[1] = C_ONE - xb;
        op_a_nxt[2] = cx;          op_b_nxt[2] = C_ONE - yl;
        op_a_nxt[3] = xt;          op_b_nxt[3] = C_ONE - cy;
      end
      PAT_BOTTOM: begin
        op_a_nxt[0] = yr;          op_b_nxt[0] = C_ONE - mx;
        op_a_nxt[1] = mx;          op_b_nxt[1] = yl;
        op_a_nxt[2] = my;          op_b_nxt[2] = C_ONE;
      end
      PAT_LEFT, PAT_RIGHT: begin
        op_a_nxt[0] = mx;          op_b_nxt[0] = C_ONE;
        op_a_nxt[1] = xt;          op_b_nxt[1] = C_ONE - my;
        op_a_nxt[2] = xb;          op_b_nxt[2] = my;
        sub_nxt  = (pat_r[DIV_STG] == PAT_RIGHT);
        base_nxt = sub_nxt;
      end
      default: begin
        // upper pair negative
        op_a_nxt[0] = my;          op_b_nxt[0] = C_ONE;
        op_a_nxt[1] = yr;          op_b_nxt[1] = C_ONE - mx;
        op_a_nxt[2] = mx;          op_b_nxt[2] = yl;
        sub_nxt  = 1'b1;
        base_nxt = 1'b1;
      end
    endcase
  end

  // Operand, product, sum and round registers
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < NPROD; i++) begin
        op_a_r[i] <= op_a_nxt[i];
        op_b_r[i] <= op_b_nxt[i];
        prod_r[i] <= PRODW'(op_a_r[i]) * PRODW'(op_b_r[i]);
      end
      op_sub_r   <= sub_nxt;
      op_base_r  <= base_nxt;
      mul_sub_r  <= op_sub_r;
      mul_base_r <= op_base_r;
      a2_r       <= a2_nxt;
      frac_r     <= frac_nxt;
    end
  end

  // Twice the negative area, 60 fraction bits
  always_comb begin
    psum = SUMW'(prod_r[0]) + SUMW'(prod_r[1]) + SUMW'(prod_r[2]) + SUMW'(prod_r[3]);
    if (mul_sub_r) a2_nxt = TWICE_ONE - A2_W'(psum);
    else if (mul_base_r) a2_nxt = TWICE_ONE + A2_W'(psum);
    else a2_nxt = A2_W'(psum);
  end

  // Clamp to [0, one] and round half up
  always_comb begin
    if (a2_r < 0) a2_clamp = '0;
    else if (a2_r > TWICE_ONE) a2_clamp = (AREA_FB+1)'(TWICE_ONE);
    else a2_clamp = a2_r[AREA_FB:0];
    a2_rnd   = a2_clamp + RND_HALF;
    frac_nxt = a2_rnd[AREA_SHIFT +: (FRAC_W+1)];
  end

  // Checks
  a_stall_only_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow a held output beat");

  a_fraction_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_negative_fraction <= ((FRAC_W+1)'(1) << FRAC_W))
    else $error("fraction above one");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> cfg_height_r == $past(cfg_wr_data))
    else $error("height register missed a write");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule
`default_nettype wire

// File: dv/cnaf_scoreboard.sv
// Checker for the cell area fraction block: predicts each result and compares it.
`timescale 1ns / 1ps
module cnaf_scoreboard (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic signed [cnaf_pkg::CORNER_W-1:0] in_corner_lower_left,
  input  logic signed [cnaf_pkg::CORNER_W-1:0] in_corner_lower_right,
  input  logic signed [cnaf_pkg::CORNER_W-1:0] in_corner_upper_left,
  input  logic signed [cnaf_pkg::CORNER_W-1:0] in_corner_upper_right,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic        [cnaf_pkg::FRAC_W:0]     out_negative_fraction,
  input  logic                                 cfg_wr_en,
  input  logic        [cnaf_pkg::CFG_W-1:0]    cfg_wr_data,
  output int                                   errors,
  output int                                   pending
);
  import cnaf_pkg::*;

  localparam longint UNIT     = 64'sd1 << 30;
  localparam longint AREA_ONE = 64'sd1 << 61;

  logic [FRAC_W:0]  fraction_q[$];
  logic [CFG_W-1:0] height_ratio;  // tracked only; the fraction does not depend on it

  // Edge crossing |a|/(|a|+|b|) with 28 fraction bits, scaled to the 30-bit unit
  function automatic longint crossing_coord(longint a, longint b);
    longint na;
    longint den;
    na  = (a < 0) ? -a : a;
    den = na + ((b < 0) ? -b : b);
    if (den == 0) return 0;
    return ((na <<< THETA_FB) / den) <<< 2;
  endfunction

  function automatic longint shoelace(longint px[5], longint py[5], int n);
    longint s;
    int     j;
    s = 0;
    for (int i = 0; i < n; i++) begin
      j = (i + 1 == n) ? 0 : i + 1;
      s += px[i] * py[j] - px[j] * py[i];
    end
    return (s < 0) ? -s : s;
  endfunction

  function automatic longint quad_area(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy);
    longint px[5];
    longint py[5];
    px = '{ax, bx, cx, dx, 0};
    py = '{ay, by, cy, dy, 0};
    return shoelace(px, py, 4);
  endfunction

  function automatic longint pent_area(longint ax, longint ay, longint bx, longint by,
                                       longint cx, longint cy, longint dx, longint dy,
                                       longint ex, longint ey);
    longint px[5];
    longint py[5];
    px = '{ax, bx, cx, dx, ex};
    py = '{ay, by, cy, dy, ey};
    return shoelace(px, py, 5);
  endfunction

  function automatic logic [FRAC_W:0] predict_fraction(longint ll, longint lr,
                                                       longint ul, longint ur);
    logic [3:0] pat;
    longint xb, xt, yl, yr, d1, d2, mx, my, cx, cy, a2;
    longint unsigned r;
    pat = {ur <= 0, ul <= 0, lr <= 0, ll <= 0};
    xb = crossing_coord(ll, lr);
    xt = crossing_coord(ul, ur);
    yl = crossing_coord(ll, ul);
    yr = crossing_coord(lr, ur);
    d1 = crossing_coord(ll, ur);
    d2 = crossing_coord(ul, lr);
    mx = (d1 + d2) / 2;
    my = (d1 + UNIT - d2) / 2;
    cx = (xb + xt + UNIT) / 4;
    cy = (yl + yr + UNIT) / 4;
    case (pat)
      PAT_NONE:      a2 = 0;
      PAT_ALL:       a2 = AREA_ONE;
      PAT_LL:        a2 = quad_area(0, 0, xb, 0, d1, d1, 0, yl);
      PAT_LR:        a2 = quad_area(UNIT, 0, UNIT, yr, d2, UNIT - d2, xb, 0);
      PAT_UL:        a2 = quad_area(0, UNIT, 0, yl, d2, UNIT - d2, xt, UNIT);
      PAT_UR:        a2 = quad_area(UNIT, UNIT, xt, UNIT, d1, d1, UNIT, yr);
      PAT_NOT_LL:    a2 = AREA_ONE - quad_area(0, 0, xb, 0, d1, d1, 0, yl);
      PAT_NOT_LR:    a2 = AREA_ONE - quad_area(UNIT, 0, UNIT, yr, d2, UNIT - d2, xb, 0);
      PAT_NOT_UL:    a2 = AREA_ONE - quad_area(0, UNIT, 0, yl, d2, UNIT - d2, xt, UNIT);
      PAT_NOT_UR:    a2 = AREA_ONE - quad_area(UNIT, UNIT, xt, UNIT, d1, d1, UNIT, yr);
      PAT_DIAG_MAIN: a2 = quad_area(0, 0, xb, 0, cx, cy, 0, yl)
                        + quad_area(UNIT, UNIT, xt, UNIT, cx, cy, UNIT, yr);
      PAT_DIAG_ANTI: a2 = quad_area(UNIT, 0, UNIT, yr, cx, cy, xb, 0)
                        + quad_area(0, UNIT, 0, yl, cx, cy, xt, UNIT);
      PAT_BOTTOM:    a2 = pent_area(0, 0, UNIT, 0, UNIT, yr, mx, my, 0, yl);
      PAT_LEFT:      a2 = pent_area(0, 0, xb, 0, mx, my, xt, UNIT, 0, UNIT);
      PAT_RIGHT:     a2 = pent_area(UNIT, 0, UNIT, UNIT, xt, UNIT, mx, my, xb, 0);
      default:       a2 = pent_area(0, UNIT, 0, yl, mx, my, UNIT, yr, UNIT, UNIT);
    endcase
    // Clamp, then round half up to the output precision
    if (a2 < 0) a2 = 0;
    if (a2 > AREA_ONE) a2 = AREA_ONE;
    r = (longint'(a2) + (64'sd1 <<< (AREA_SHIFT - 1))) >> AREA_SHIFT;
    if (r > (64'd1 << FRAC_W)) r = 64'd1 << FRAC_W;
    return r[FRAC_W:0];
  endfunction

  assign pending = fraction_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      height_ratio <= CFG_HEIGHT_RST;
      errors       <= 0;
      fraction_q.delete();
    end else begin
      if (cfg_wr_en) height_ratio <= cfg_wr_data;
      // Predict on every accepted input beat
      if (in_valid && !in_stall)
        fraction_q.push_back(predict_fraction(in_corner_lower_left, in_corner_lower_right,
                                              in_corner_upper_left, in_corner_upper_right));
      // Compare every accepted result beat with the oldest prediction
      if (out_valid && !out_stall) begin
        if (fraction_q.size() == 0) begin
          $display("%0t: unexpected result beat, negative_fraction=%0d",
                   $time, out_negative_fraction);
          errors <= errors + 1;
        end else if (fraction_q[0] !== out_negative_fraction) begin
          $display("%0t: negative_fraction mismatch, expected %0d, actual %0d",
                   $time, fraction_q[0], out_negative_fraction);
          errors <= errors + 1;
          void'(fraction_q.pop_front());
        end else begin
          void'(fraction_q.pop_front());
        end
      end
    end
  end

endmodule

// File: dv/tb_cell_negative_area_fraction.sv
// Testbench top for the cell area fraction block: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps
module tb_cell_negative_area_fraction;
  import cnaf_pkg::*;

  localparam int LATENCY    = 12;
  localparam int IDLE_LIMIT = 5000;
  localparam int N_RANDOM   = 480;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic signed [CORNER_W-1:0] corner_ll, corner_lr, corner_ul, corner_ur;
  logic                       out_valid;
  logic                       out_stall;
  logic        [FRAC_W:0]     out_fraction;
  logic                       cfg_wr_en;
  logic        [CFG_W-1:0]    cfg_wr_data;
  int                         errors;
  int                         pending;
  logic                       hold_request;
  int                         idle_cycles;

  cell_negative_area_fraction dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_corner_lower_left  (corner_ll),
    .in_corner_lower_right (corner_lr),
    .in_corner_upper_left  (corner_ul),
    .in_corner_upper_right (corner_ur),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_negative_fraction (out_fraction),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data)
  );

  cnaf_scoreboard checker_i (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_corner_lower_left  (corner_ll),
    .in_corner_lower_right (corner_lr),
    .in_corner_upper_left  (corner_ul),
    .in_corner_upper_right (corner_ur),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_negative_fraction (out_fraction),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_wr_data           (cfg_wr_data),
    .errors                (errors),
    .pending               (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Corner value biased toward zero, extremes and small magnitudes
  function automatic logic signed [CORNER_W-1:0] pick_corner();
    case ($urandom_range(0, 7))
      0:       return 16'sd0;
      1:       return -16'sd32768;
      2:       return 16'sd32767;
      3:       return ($urandom_range(0, 1) != 0) ? 16'sd1 : -16'sd1;
      4:       return $signed(16'($urandom_range(0, 255)) - 16'd128);
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  task automatic send_cell(input logic signed [CORNER_W-1:0] ll, lr, ul, ur);
    int gap;
    @(negedge clk);
    in_valid  <= 1'b1;
    corner_ll <= ll;
    corner_lr <= lr;
    corner_ul <= ul;
    corner_ur <= ur;
    // Hold the beat until accepted
    do @(posedge clk); while (in_stall);
    gap = gap_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_height(input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random(input int count);
    logic signed [CORNER_W-1:0] c[4];
    logic [3:0] pat;
    for (int i = 0; i < count; i++) begin
      foreach (c[k]) c[k] = pick_corner();
      // Force a random sign pattern half the time so all 16 cases stay busy
      if ($urandom_range(0, 1) != 0) begin
        pat = 4'($urandom());
        foreach (c[k])
          if (pat[k] && c[k] > 0) c[k] = -c[k];
          else if (!pat[k] && c[k] <= 0) c[k] = (c[k] == 0 || c[k] == -16'sd32768) ?
                                                16'sd7 : -c[k];
      end
      send_cell(c[0], c[1], c[2], c[3]);
    end
  endtask

  // Receiver: random stalls, plus one long hold on request
  initial begin
    int n;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (150) @(negedge clk);
        hold_request = 1'b0;
        out_stall <= 1'b0;
      end else begin
        n = gap_len();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(negedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    hold_request = 1'b0;
    in_valid    <= 1'b0;
    corner_ll   <= '0;
    corner_lr   <= '0;
    corner_ul   <= '0;
    corner_ur   <= '0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    rst_n       <= 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: extremes, all-zero, every sign pattern except PAT_NOT_UL and PAT_NOT_LR
    write_height(16'd1);
    send_cell(0, 0, 0, 0);
    send_cell(-32768, -32768, -32768, -32768);
    send_cell(32767, 32767, 32767, 32767);
    send_cell(-32768, 32767, 32767, 32767);
    send_cell(32767, -32768, 32767, 32767);
    send_cell(32767, 32767, -32768, 32767);
    send_cell(32767, 32767, 32767, -32768);
    send_cell(0, 1, 1, 1);
    send_cell(1, 0, 0, 0);
    send_cell(-5, -5, 7, 7);
    send_cell(-5, 7, -5, 7);
    send_cell(7, -5, 7, -5);
    send_cell(7, 7, -5, -5);
    send_cell(-100, 100, 100, -100);
    send_cell(100, -100, -100, 100);
    send_cell(-1, 32767, 32767, -1);
    send_cell(32767, -32768, -32768, 32767);
    send_cell(-300, -200, -100, 400);
    send_cell(-32768, 1, 1, 1);
    send_cell(1, -32768, -32768, -32768);
    send_cell(-32768, -32768, 1, 32767);
    drain();

    write_height(16'd65535);
    send_random(N_RANDOM / 3);

    // Let the receiver hold off while input keeps coming
    hold_request = 1'b1;
    send_random(60);
    drain();

    write_height(16'd256);
    send_random(N_RANDOM / 3);
    drain();

    write_height(16'($urandom_range(1, 65535)));
    send_random(N_RANDOM / 3 - 60);
    drain();

    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/cnaf_pkg.sv
rtl/cell_negative_area_fraction.sv
dv/cnaf_scoreboard.sv
dv/tb_cell_negative_area_fraction.sv
